// ===== rtl/trcs_pkg.sv =====
// Package for the tristate remote code sender: reset values, register indexes, segment codes.
package trcs_pkg;

  // Default code length
  localparam int CODE_BITS_DEF = 12;

  // Field widths fixed by the interface
  localparam int CODE_IN_W  = 12;
  localparam int UNIT_W     = 16;
  localparam int REPEAT_W   = 4;
  localparam int SYNC_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register reset values
  localparam logic [UNIT_W-1:0]   UNIT_TICKS_RST     = 16'd350;
  localparam logic [REPEAT_W-1:0] REPEAT_COUNT_RST   = 4'd6;
  localparam logic [SYNC_W-1:0]   SYNC_LOW_UNITS_RST = 6'd31;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UNIT_TICKS     = 2'd0,
    CFG_REPEAT_COUNT   = 2'd1,
    CFG_SYNC_LOW_UNITS = 2'd2,
    CFG_UNUSED         = 2'd3
  } cfg_idx_t;

  // Pulse segment within one bit; the sync pulse uses only the first two
  typedef enum logic [1:0] {
    SEG_HIGH_A = 2'd0,
    SEG_LOW_A  = 2'd1,
    SEG_HIGH_B = 2'd2,
    SEG_LOW_B  = 2'd3
  } seg_t;

  // One result per tick
  typedef struct packed {
    logic                 pin_level;
    logic                 busy_res;
    logic [CODE_IN_W-1:0] sent_code;
    logic                 frame_done;
  } res_t;

endpackage

// ===== rtl/tristate_remote_code_sender_core.sv =====
// Tristate remote code sender: tick-driven waveform sequencer with registered result and skid stage.
//
// Usage:
//   Input channel (in_valid / in_stall): one transfer per time tick carrying in_start_req,
//   in_code and in_adjust. A start on an idle tick latches the code (after the optional
//   toggle adjust) and that same tick is the first high tick of the waveform. Starts while
//   busy are ignored.
//   Result channel (out_valid / out_stall): exactly one result per input tick, giving the
//   pin level, busy flag, code being sent and a done flag on the final tick.
//   Config channel (cfg_valid / cfg_ready, always ready): index 0 unit_ticks, 1 repeat_count,
//   2 sync_low_units; other indexes are ignored. Write while idle.
// Timing:
//   The result of an accepted tick is registered in the output register (or the skid stage
//   when stalled). Throughput is one tick per cycle while in_stall is low: the sequencer
//   update is a single 16-bit and a 6-bit increment-and-compare between state and result registers.
// Reset: synchronous active-low rst_n returns the sequencer to idle, empties both result
//   stages and restores the register defaults (350, 6, 31).
// Stall: a stalled result is held in the output register; one more tick is taken into the
//   skid stage, after which in_stall rises until the receiver drains it.
module tristate_remote_code_sender_core
  import trcs_pkg::*;
#(
  parameter int CODE_BITS = CODE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input ticks
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_start_req,
  input  logic [CODE_IN_W-1:0]  in_code,
  input  logic                  in_adjust,
  // results
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_pin_level,
  output logic                  out_busy_res,
  output logic [CODE_IN_W-1:0]  out_sent_code,
  output logic                  out_frame_done,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;
  localparam logic [IDX_W-1:0] LAST_BIT = IDX_W'(CODE_BITS - 1);

  // configuration registers
  logic [UNIT_W-1:0]   unit_ticks_r;
  logic [REPEAT_W-1:0] repeat_count_r;
  logic [SYNC_W-1:0]   sync_low_units_r;

  // sequencer state
  logic [CODE_BITS-1:0] code_r, code_nxt;
  logic [REPEAT_W-1:0]  repeat_r, repeat_nxt;
  logic [IDX_W-1:0]     bit_r, bit_nxt;
  seg_t                 seg_r, seg_nxt;
  logic                 sync_r, sync_nxt;
  logic [SYNC_W-1:0]    unit_r, unit_nxt;
  logic [UNIT_W-1:0]    tick_r, tick_nxt;
  logic                 busy_r, busy_nxt;

  // result stages
  res_t res_nxt, out_r, skid_r;
  logic out_v_r, skid_v_r;

  logic acc, out_fire;

  // working values
  logic [CODE_BITS+CODE_IN_W-1:0] code_ext, sent_ext;
  logic [CODE_BITS-1:0] c_new;
  logic                 start;
  logic [CODE_BITS-1:0] e_code;
  logic [REPEAT_W-1:0]  e_rep;
  logic [IDX_W-1:0]     e_bit;
  seg_t                 e_seg;
  logic                 e_sync;
  logic [SYNC_W-1:0]    e_unit;
  logic [UNIT_W-1:0]    e_tick;
  logic                 e_busy;
  logic [UNIT_W-1:0]    ticks_len, tick_inc;
  logic [SYNC_W-1:0]    units_len, unit_inc;
  logic                 cur_bit;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_v_r;
  assign acc       = in_valid && !in_stall;
  assign out_fire  = out_v_r && !out_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_ticks_r     <= UNIT_TICKS_RST;
      repeat_count_r   <= REPEAT_COUNT_RST;
      sync_low_units_r <= SYNC_LOW_UNITS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_UNIT_TICKS:     unit_ticks_r     <= cfg_data;
        CFG_REPEAT_COUNT:   repeat_count_r   <= cfg_data[REPEAT_W-1:0];
        CFG_SYNC_LOW_UNITS: sync_low_units_r <= cfg_data[SYNC_W-1:0];
        default: ;
      endcase
    end
  end

  // code fit to CODE_BITS and the toggle rule
  always_comb begin
    code_ext = {{CODE_BITS{1'b0}}, in_code};
    c_new    = code_ext[CODE_BITS-1:0];
    if (in_adjust) begin
      if (c_new[0]) c_new = c_new + CODE_BITS'(1);
      else          c_new = c_new - CODE_BITS'(1);
    end
  end

  // effective state for this tick: a start on an idle tick reloads everything
  always_comb begin
    start  = !busy_r && in_start_req;
    e_code = code_r;
    e_rep  = repeat_r;
    e_bit  = bit_r;
    e_seg  = seg_r;
    e_sync = sync_r;
    e_unit = unit_r;
    e_tick = tick_r;
    e_busy = busy_r;
    if (start) begin
      e_code = c_new;
      e_rep  = (repeat_count_r == '0) ? REPEAT_W'(1) : repeat_count_r;
      e_bit  = LAST_BIT;
      e_seg  = SEG_HIGH_A;
      e_sync = 1'b0;
      e_unit = '0;
      e_tick = '0;
      e_busy = 1'b1;
    end
  end

  // segment lengths
  always_comb begin
    ticks_len = (unit_ticks_r == '0) ? UNIT_W'(1) : unit_ticks_r;
    cur_bit   = e_code[e_bit];
    if (e_sync) begin
      if (e_seg == SEG_HIGH_A) units_len = SYNC_W'(1);
      else units_len = (sync_low_units_r == '0) ? SYNC_W'(1) : sync_low_units_r;
    end else begin
      case (e_seg)
        SEG_HIGH_A: units_len = SYNC_W'(1);
        SEG_LOW_A:  units_len = SYNC_W'(3);
        SEG_HIGH_B: units_len = cur_bit ? SYNC_W'(1) : SYNC_W'(3);
        default:    units_len = cur_bit ? SYNC_W'(3) : SYNC_W'(1);
      endcase
    end
    tick_inc = e_tick + UNIT_W'(1);
    unit_inc = e_unit + SYNC_W'(1);
  end

  // sequencer step and result
  always_comb begin
    code_nxt   = code_r;
    repeat_nxt = repeat_r;
    bit_nxt    = bit_r;
    seg_nxt    = seg_r;
    sync_nxt   = sync_r;
    unit_nxt   = unit_r;
    tick_nxt   = tick_r;
    busy_nxt   = busy_r;
    res_nxt    = '0;
    sent_ext   = {{CODE_IN_W{1'b0}}, e_code};
    if (e_busy) begin
      res_nxt.pin_level = ~e_seg[0];
      res_nxt.busy_res  = 1'b1;
      res_nxt.sent_code = sent_ext[CODE_IN_W-1:0];
      code_nxt   = e_code;
      repeat_nxt = e_rep;
      bit_nxt    = e_bit;
      seg_nxt    = e_seg;
      sync_nxt   = e_sync;
      unit_nxt   = e_unit;
      busy_nxt   = 1'b1;
      if (tick_inc < ticks_len && tick_inc != '0) begin
        tick_nxt = tick_inc;
      end else begin
        tick_nxt = '0;
        if (unit_inc < units_len && unit_inc != '0) begin
          unit_nxt = unit_inc;
        end else begin
          unit_nxt = '0;
          if (!e_sync) begin
            // data bit: walk the four segments, then the next bit or the sync
            if (e_seg != SEG_LOW_B) begin
              seg_nxt = seg_t'(e_seg + 2'd1);
            end else begin
              seg_nxt = SEG_HIGH_A;
              if (e_bit == '0) sync_nxt = 1'b1;
              else bit_nxt = e_bit - IDX_W'(1);
            end
          end else if (e_seg == SEG_HIGH_A) begin
            seg_nxt = SEG_LOW_A;
          end else begin
            // end of frame: repeat or finish
            seg_nxt  = SEG_HIGH_A;
            sync_nxt = 1'b0;
            if (e_rep <= REPEAT_W'(1)) begin
              repeat_nxt         = '0;
              busy_nxt           = 1'b0;
              res_nxt.frame_done = 1'b1;
            end else begin
              repeat_nxt = e_rep - REPEAT_W'(1);
              bit_nxt    = LAST_BIT;
            end
          end
        end
      end
    end
  end

  // state registers advance once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r   <= '0;
      repeat_r <= '0;
      bit_r    <= '0;
      seg_r    <= SEG_HIGH_A;
      sync_r   <= 1'b0;
      unit_r   <= '0;
      tick_r   <= '0;
      busy_r   <= 1'b0;
    end else if (acc) begin
      code_r   <= code_nxt;
      repeat_r <= repeat_nxt;
      bit_r    <= bit_nxt;
      seg_r    <= seg_nxt;
      sync_r   <= sync_nxt;
      unit_r   <= unit_nxt;
      tick_r   <= tick_nxt;
      busy_r   <= busy_nxt;
    end
  end

  // output register and skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_fire) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= acc;
      end
    end else if (acc) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_fire) begin
      if (skid_v_r) out_r <= skid_r;
      else if (acc) out_r <= res_nxt;
    end else if (acc) begin
      skid_r <= res_nxt;
    end
  end

  assign out_valid      = out_v_r;
  assign out_pin_level  = out_r.pin_level;
  assign out_busy_res   = out_r.busy_res;
  assign out_sent_code  = out_r.sent_code;
  assign out_frame_done = out_r.frame_done;

  // skid holds data only behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid stage full while output register empty");

  // idle sequencer rests at the first segment outside the sync
  a_idle_rest: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (seg_r == SEG_HIGH_A && !sync_r && unit_r == '0 && tick_r == '0))
    else $error("idle sequencer not at rest");

  // sync pulse follows the last bit and has only two segments
  a_sync_shape: assert property (@(posedge clk) disable iff (!rst_n)
    sync_r |-> (bit_r == '0 && (seg_r == SEG_HIGH_A || seg_r == SEG_LOW_A)))
    else $error("sync pulse in an invalid position");

  // a finished transmission drops busy and clears the repeat count
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && res_nxt.frame_done) |=> (!busy_r && repeat_r == '0))
    else $error("done tick did not return sequencer to idle");

endmodule

// ===== test/tristate_remote_code_sender_core_tb.sv =====
// Testbench for the tristate remote code sender: tick stream in, predicted pin waveform checked.
`timescale 1ns / 1ps

module tristate_remote_code_sender_core_tb;
  import trcs_pkg::*;

  // One tick as offered on the input channel
  typedef struct packed {
    logic                 start;
    logic [CODE_IN_W-1:0] code;
    logic                 adjust;
  } tick_t;

  // Receiver stall patterns
  typedef enum logic [1:0] {
    RX_FREE   = 2'd0,
    RX_LIGHT  = 2'd1,
    RX_HEAVY  = 2'd2,
    RX_TOGGLE = 2'd3
  } rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_start_req = 1'b0;
  logic [CODE_IN_W-1:0]  in_code = '0;
  logic                  in_adjust = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_pin_level;
  logic                  out_busy_res;
  logic [CODE_IN_W-1:0]  out_sent_code;
  logic                  out_frame_done;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  tristate_remote_code_sender_core u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_start_req  (in_start_req),
    .in_code       (in_code),
    .in_adjust     (in_adjust),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pin_level (out_pin_level),
    .out_busy_res  (out_busy_res),
    .out_sent_code (out_sent_code),
    .out_frame_done(out_frame_done),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  tick_t tick_q[$];        // ticks waiting to be offered
  res_t  waveform_q[$];    // expected per-tick pin results
  int    mismatches = 0;
  int    ticks_sent = 0;

  // Predictor copy of the timing registers
  logic [UNIT_W-1:0]   unit_len = UNIT_TICKS_RST;
  logic [REPEAT_W-1:0] frames   = REPEAT_COUNT_RST;
  logic [SYNC_W-1:0]   sync_len = SYNC_LOW_UNITS_RST;

  // Predictor copy of the sequencer
  logic [CODE_IN_W-1:0] code_r    = '0;
  logic [REPEAT_W-1:0]  reps_left = '0;
  logic [3:0]           bit_idx   = '0;
  seg_t                 seg       = SEG_HIGH_A;
  logic                 syncing   = 1'b0;
  logic [SYNC_W-1:0]    units     = '0;
  logic [UNIT_W-1:0]    ticks     = '0;
  logic                 sending   = 1'b0;

  // Advance the predicted waveform by one tick and return what the pin shows on it
  function automatic res_t encode_tick(tick_t t);
    res_t              r;
    logic [UNIT_W-1:0] tick_len;
    logic [SYNC_W-1:0] seg_len;
    logic              one;
    logic              lvl;
    logic              done;
    r = '0;
    done = 1'b0;
    // start is only taken while idle, the adjust rule with it
    if (!sending && t.start) begin
      code_r = t.code;
      if (t.adjust)
        code_r = code_r[0] ? code_r + 12'd1 : code_r - 12'd1;
      reps_left = (frames == '0) ? 4'd1 : frames;
      bit_idx = 4'(CODE_BITS_DEF - 1);
      seg = SEG_HIGH_A;
      syncing = 1'b0;
      units = '0;
      ticks = '0;
      sending = 1'b1;
    end
    if (!sending)
      return r;
    lvl = (seg == SEG_HIGH_A) || (seg == SEG_HIGH_B);
    r.sent_code = code_r;
    tick_len = (unit_len == '0) ? 16'd1 : unit_len;
    ticks = ticks + 16'd1;
    if (ticks >= tick_len || ticks == '0) begin
      ticks = '0;
      units = units + 6'd1;
      // length of the current segment in units
      if (syncing) begin
        seg_len = (seg == SEG_HIGH_A) ? 6'd1 : ((sync_len == '0) ? 6'd1 : sync_len);
      end else begin
        one = code_r[bit_idx];
        case (seg)
          SEG_HIGH_A: seg_len = 6'd1;
          SEG_LOW_A:  seg_len = 6'd3;
          SEG_HIGH_B: seg_len = one ? 6'd1 : 6'd3;
          default:    seg_len = one ? 6'd3 : 6'd1;
        endcase
      end
      if (units >= seg_len || units == '0) begin
        units = '0;
        if (!syncing) begin
          if (seg != SEG_LOW_B) begin
            seg = seg_t'(seg + 2'd1);
          end else begin
            seg = SEG_HIGH_A;
            if (bit_idx == '0)
              syncing = 1'b1;
            else
              bit_idx = bit_idx - 4'd1;
          end
        end else if (seg == SEG_HIGH_A) begin
          seg = SEG_LOW_A;
        end else begin
          // end of sync: next frame or end of transmission
          seg = SEG_HIGH_A;
          syncing = 1'b0;
          if (reps_left <= 4'd1) begin
            reps_left = '0;
            sending = 1'b0;
            done = 1'b1;
          end else begin
            reps_left = reps_left - 4'd1;
            bit_idx = 4'(CODE_BITS_DEF - 1);
          end
        end
      end
    end
    r.pin_level = lvl;
    r.busy_res = 1'b1;
    r.frame_done = done;
    return r;
  endfunction

  // Input driver: bursts of random length, random gaps between them
  int burst_left = 1;
  int gap_left = 0;
  tick_t cur_tick = '0;

  always @(posedge clk) begin : drive_ticks
    tick_t nxt;
    res_t  r;
    logic  took;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      took = in_valid && !in_stall;
      if (took) begin
        r = encode_tick(cur_tick);
        waveform_q.push_back(r);
        ticks_sent++;
      end
      if (!in_valid || took) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (tick_q.size() > 0) begin
          nxt = tick_q.pop_front();
          cur_tick = nxt;
          in_start_req <= nxt.start;
          in_code <= nxt.code;
          in_adjust <= nxt.adjust;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string what, input logic [11:0] want,
                             input logic [11:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Result monitor and receiver stall pattern, with a long hold-off now and then
  always @(posedge clk) begin : watch_results
    res_t            e;
    int unsigned     cyc;
    int              hold_left;
    rx_mode_t        rx_mode;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (waveform_q.size() == 0) begin
          $display({"%0t ns: unexpected result, expected none, ",
                    "actual pin %0b busy %0b code %0h done %0b"},
                   $time, out_pin_level, out_busy_res, out_sent_code, out_frame_done);
          mismatches++;
        end else begin
          e = waveform_q.pop_front();
          check_field("pin_level", 12'(e.pin_level), 12'(out_pin_level));
          check_field("busy_res", 12'(e.busy_res), 12'(out_busy_res));
          check_field("sent_code", e.sent_code, out_sent_code);
          check_field("frame_done", 12'(e.frame_done), 12'(out_frame_done));
        end
      end
      cyc++;
      if (cyc % 1000 == 40)
        hold_left = 60;
      if (cyc % 64 == 0)
        rx_mode = rx_mode_t'($urandom_range(0, 3));
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (rx_mode)
          RX_FREE:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:  out_stall <= ~out_stall;
        endcase
      end
    end
  end

  task automatic push_tick(input logic start, input logic [CODE_IN_W-1:0] code,
                           input logic adjust);
    tick_t t;
    t.start = start;
    t.code = code;
    t.adjust = adjust;
    tick_q.push_back(t);
  endtask

  // n ticks with random code and adjust, start set with the given percentage
  task automatic queue_ticks(input int n, input int start_pct);
    for (int i = 0; i < n; i++)
      push_tick($urandom_range(0, 99) < start_pct, CODE_IN_W'($urandom), 1'($urandom));
  endtask

  // Sender pauses until every tick has been offered and every result has come back
  task automatic wait_drained();
    while (tick_q.size() != 0 || in_valid || waveform_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    case (idx)
      CFG_UNIT_TICKS:     unit_len = val;
      CFG_REPEAT_COUNT:   frames = val[REPEAT_W-1:0];
      CFG_SYNC_LOW_UNITS: sync_len = val[SYNC_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_timing(input int ut, input int rep, input int sl);
    wait_drained();
    write_reg(CFG_UNIT_TICKS, CFG_DATA_W'(ut));
    write_reg(CFG_REPEAT_COUNT, CFG_DATA_W'(rep));
    write_reg(CFG_SYNC_LOW_UNITS, CFG_DATA_W'(sl));
  endtask

  // Stimulus
  initial begin : stimulus
    int random_ticks;
    int tx_len;
    int pct;
    random_ticks = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single frame, default unit and sync lengths
    write_reg(CFG_REPEAT_COUNT, 16'd1);

    // directed: idle tick, start with decrement wrap, starts while busy ignored
    push_tick(1'b0, 12'hFFF, 1'b1);
    push_tick(1'b1, 12'h000, 1'b1);
    push_tick(1'b1, 12'h555, 1'b0);
    push_tick(1'b1, 12'hAAA, 1'b1);
    queue_ticks(100, 30);
    // zero lengths written mid-transmission, tick counter already past the new length
    set_timing(0, 0, 0);
    write_reg(CFG_UNUSED, 16'hFFFF);
    queue_ticks(100, 0);
    // increment wrap
    push_tick(1'b1, 12'hFFF, 1'b1);
    queue_ticks(99, 0);

    // random phases with short timing
    while (random_ticks < 180) begin
      set_timing($urandom_range(0, 2), $urandom_range(0, 2), $urandom_range(0, 4));
      pct = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(2, 40);
      tx_len = $urandom_range(40, 120);
      queue_ticks(tx_len, pct);
      random_ticks += tx_len;
    end

    // widest unit, then shrunk while the tick counter is past it
    set_timing(65535, 1, 1);
    push_tick(1'b1, 12'h801, 1'b0);
    queue_ticks(20, 0);
    wait_drained();
    write_reg(CFG_UNIT_TICKS, 16'd1);
    queue_ticks(100, 20);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("** tristate_remote_code_sender_core: PASSED **");
    else
      $display("** tristate_remote_code_sender_core: FAILED **");
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #(100_000_000);
    $display("** tristate_remote_code_sender_core: FAILED **");
    $finish;
  end

endmodule
